>>> rtl/gtp_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and the arctangent table for the go-to-point drive controller.
// No dependencies; every other file imports this package.
package gtp_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int ATAN_ENTRIES = 24;

    localparam int POS_W  = 16;
    localparam int HEAD_W = 15;
    localparam int SPD_W  = 14;
    localparam int ACT_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam int DIFF_W = POS_W + 1;
    localparam int CX_W   = 28;
    localparam int CZ_W   = 32;

    localparam logic signed [CZ_W-1:0] HALF_TURN_Z = 32'sd754974720;
    localparam int INV_GAIN_W = 30;
    localparam logic [INV_GAIN_W-1:0] INV_GAIN_Q30 = 30'd652032874;
    localparam int DIST_SHIFT = 38;

    localparam int ARRIVE_DIST  = 64;
    localparam int FWD_CAP      = 800;
    localparam int FWD_CAP_DIST = 16020;
    localparam int FWD_W        = 10;
    localparam int DIV_IN_W     = 14;
    localparam int DIV20_W      = 15;
    localparam int DIV20_RECIP  = 26215;
    localparam int DIV20_SHIFT  = 19;

    localparam logic [ACT_W-1:0] ACT_HOLD   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SPIN   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_STOP   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_ARRIVE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_OVR  = 2'd2;

    typedef struct packed {
        logic signed [CX_W-1:0] x;
        logic signed [CZ_W-1:0] z;
    } t_cordic_res;

    typedef struct packed {
        logic                    near;
        logic signed [SPD_W-1:0] left;
        logic signed [SPD_W-1:0] right;
    } t_post_res;

    // arctan(2^-i) in 2^-22 degree, rounded to nearest
    function automatic logic signed [CZ_W-1:0] atan_val(input logic [4:0] idx);
        logic signed [CZ_W-1:0] v;
        case (idx)
            5'd0:  v = 32'sd188743680;
            5'd1:  v = 32'sd111421900;
            5'd2:  v = 32'sd58872272;
            5'd3:  v = 32'sd29884485;
            5'd4:  v = 32'sd15000234;
            5'd5:  v = 32'sd7507429;
            5'd6:  v = 32'sd3754631;
            5'd7:  v = 32'sd1877430;
            5'd8:  v = 32'sd938729;
            5'd9:  v = 32'sd469366;
            5'd10: v = 32'sd234683;
            5'd11: v = 32'sd117342;
            5'd12: v = 32'sd58671;
            5'd13: v = 32'sd29335;
            5'd14: v = 32'sd14668;
            5'd15: v = 32'sd7334;
            5'd16: v = 32'sd3667;
            5'd17: v = 32'sd1833;
            5'd18: v = 32'sd917;
            5'd19: v = 32'sd458;
            5'd20: v = 32'sd229;
            5'd21: v = 32'sd115;
            5'd22: v = 32'sd57;
            5'd23: v = 32'sd29;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/go_to_point_drive_controller.sv
`timescale 1ns / 1ps
// Go-to-point drive controller: sequencer, configuration registers and result register.
// Depends on gtp_pkg, gtp_cordic and gtp_post.
//
// Usage: one input transfer per control tick carries the measured pose and the run key;
// exactly one result transfer follows with the action code and the wheel speeds.
// Configuration transfers (index 0 target x, 1 target y, 2 run override) are taken in
// any cycle and must only be issued while no tick is in flight; a write to a known
// register clears the arrived latch.
// A tick that needs steering passes through the CORDIC unit, which does one rotation per
// cycle, and then through four post-processing steps before reaching the result register;
// a hold or stop tick goes straight to the result register. o_in_ready is high only while
// the sequencer is idle.
// A finished result sits in the output register; if the receiver stalls, the next
// tick may still be taken and is held at its end until the register frees up.
// Reset clears the targets, the override, the driving and arrived latches and any
// pending result.
module go_to_point_drive_controller import gtp_pkg::*; #(
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic [HEAD_W-1:0]       i_heading,
    input  logic                    i_run_key,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [ACT_W-1:0]        o_action,
    output logic signed [SPD_W-1:0] o_left_speed,
    output logic signed [SPD_W-1:0] o_right_speed,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DAT_W-1:0]    i_cfg_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CORDIC = 2'd1;
    localparam logic [1:0] ST_POST   = 2'd2;
    localparam logic [1:0] ST_OUT    = 2'd3;

    logic [1:0]              r_state, n_state;
    logic signed [POS_W-1:0] r_tx, n_tx, r_ty, n_ty;
    logic                    r_ovr, n_ovr;
    logic                    r_driving, n_driving, r_arrived, n_arrived;
    logic [HEAD_W-1:0]       r_heading, n_heading;
    logic [ACT_W-1:0]        r_act, n_act;
    logic signed [SPD_W-1:0] r_left, n_left, r_right, n_right;
    logic                    r_out_valid, n_out_valid;
    logic [ACT_W-1:0]        r_o_act, n_o_act;
    logic signed [SPD_W-1:0] r_o_left, n_o_left, r_o_right, n_o_right;

    logic                     w_in_acc, w_cfg_acc, w_cfg_known, w_go;
    logic signed [DIFF_W-1:0] w_dx, w_dy;
    logic                     w_cordic_done, w_post_done;
    t_cordic_res              w_cordic_res;
    t_post_res                w_post_res;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_cfg_known = (i_cfg_index == REG_TARGET_X) || (i_cfg_index == REG_TARGET_Y)
                      || (i_cfg_index == REG_RUN_OVR);
    assign w_go        = w_in_acc && !r_arrived && (i_run_key || r_ovr);
    assign w_dx        = {r_tx[POS_W-1], r_tx} - {i_pos_x[POS_W-1], i_pos_x};
    assign w_dy        = {r_ty[POS_W-1], r_ty} - {i_pos_y[POS_W-1], i_pos_y};

    gtp_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_go),
        .i_dx    (w_dx),
        .i_dy    (w_dy),
        .o_done  (w_cordic_done),
        .o_res   (w_cordic_res)
    );

    gtp_post u_post (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_cordic_done),
        .i_res     (w_cordic_res),
        .i_heading (r_heading),
        .o_done    (w_post_done),
        .o_res     (w_post_res)
    );

    always_comb begin
        n_state     = r_state;
        n_tx        = r_tx;
        n_ty        = r_ty;
        n_ovr       = r_ovr;
        n_driving   = r_driving;
        n_arrived   = r_arrived;
        n_heading   = r_heading;
        n_act       = r_act;
        n_left      = r_left;
        n_right     = r_right;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_act     = r_o_act;
        n_o_left    = r_o_left;
        n_o_right   = r_o_right;

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_heading = i_heading;
                    n_left    = '0;
                    n_right   = '0;
                    if (w_go) begin
                        n_state = ST_CORDIC;
                    end else begin
                        n_state = ST_OUT;
                        n_act   = ACT_HOLD;
                        if (!r_arrived && r_driving) begin
                            n_act     = ACT_STOP;
                            n_driving = 1'b0;
                        end
                    end
                end
            end
            ST_CORDIC: begin
                if (w_cordic_done) begin
                    n_state = ST_POST;
                end
            end
            ST_POST: begin
                if (w_post_done) begin
                    n_state = ST_OUT;
                    if (w_post_res.near) begin
                        n_act     = ACT_ARRIVE;
                        n_arrived = 1'b1;
                        n_driving = 1'b0;
                    end else begin
                        n_act     = ACT_SPIN;
                        n_left    = w_post_res.left;
                        n_right   = w_post_res.right;
                        n_driving = 1'b1;
                    end
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_act     = r_act;
                    n_o_left    = r_left;
                    n_o_right   = r_right;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_cfg_acc) begin
            case (i_cfg_index)
                REG_TARGET_X: n_tx  = i_cfg_data;
                REG_TARGET_Y: n_ty  = i_cfg_data;
                REG_RUN_OVR:  n_ovr = i_cfg_data[0];
                default: ;
            endcase
            if (w_cfg_known) begin
                n_arrived = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tx        <= '0;
            r_ty        <= '0;
            r_ovr       <= 1'b0;
            r_driving   <= 1'b0;
            r_arrived   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tx        <= n_tx;
            r_ty        <= n_ty;
            r_ovr       <= n_ovr;
            r_driving   <= n_driving;
            r_arrived   <= n_arrived;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_heading <= n_heading;
        r_act     <= n_act;
        r_left    <= n_left;
        r_right   <= n_right;
        r_o_act   <= n_o_act;
        r_o_left  <= n_o_left;
        r_o_right <= n_o_right;
    end

    assign o_out_valid   = r_out_valid;
    assign o_action      = r_o_act;
    assign o_left_speed  = r_o_left;
    assign o_right_speed = r_o_right;

`ifndef SYNTHESIS
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("input taken while a tick is in flight");

    a_speeds_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_action != ACT_SPIN)) |-> (o_left_speed == '0 && o_right_speed == '0))
        else $error("nonzero speed without spin action");

    a_cfg_clears_arrived: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_acc && (i_cfg_index == REG_TARGET_X || i_cfg_index == REG_TARGET_Y
            || i_cfg_index == REG_RUN_OVR)) |=> !r_arrived)
        else $error("arrived latch survived a configuration write");

    a_post_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_post_done |-> (r_state == ST_POST))
        else $error("post-processing finished outside its state");
`endif

endmodule

>>> rtl/gtp_cordic.sv
`timescale 1ns / 1ps
// Iterative CORDIC vectoring unit: one shift-add rotation per cycle on x, y and angle.
// Depends on gtp_pkg for widths, the half-turn constant and the arctangent table.
module gtp_cordic import gtp_pkg::*; #(
    parameter int ITERATIONS = CORDIC_ITERATIONS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DIFF_W-1:0] i_dx,
    input  logic signed [DIFF_W-1:0] i_dy,
    output logic                     o_done,
    output t_cordic_res              o_res
);

    localparam int NI = (ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : ITERATIONS;
    localparam int CW = (NI > 1) ? $clog2(NI) : 1;

    logic signed [CX_W-1:0] r_x, n_x, r_y, n_y;
    logic signed [CZ_W-1:0] r_z, n_z;
    logic [CW-1:0]          r_iter, n_iter;
    logic                   r_busy, n_busy, r_done, n_done;
    logic signed [CX_W-1:0] w_x0, w_y0, w_xs, w_ys;
    logic signed [CZ_W-1:0] w_atan;

    assign w_x0   = {{(CX_W-DIFF_W-8){i_dx[DIFF_W-1]}}, i_dx, 8'd0};
    assign w_y0   = {{(CX_W-DIFF_W-8){i_dy[DIFF_W-1]}}, i_dy, 8'd0};
    assign w_xs   = r_x >>> r_iter;
    assign w_ys   = r_y >>> r_iter;
    assign w_atan = atan_val(5'(r_iter));

    always_comb begin
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_iter = r_iter;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_iter = '0;
            if (w_x0 < 0) begin
                n_x = -w_x0;
                n_y = -w_y0;
                n_z = (w_y0 >= 0) ? HALF_TURN_Z : -HALF_TURN_Z;
            end else begin
                n_x = w_x0;
                n_y = w_y0;
                n_z = '0;
            end
        end else if (r_busy) begin
            if (r_y < 0) begin
                n_x = r_x - w_ys;
                n_y = r_y + w_xs;
                n_z = r_z - w_atan;
            end else begin
                n_x = r_x + w_ys;
                n_y = r_y - w_xs;
                n_z = r_z + w_atan;
            end
            if (r_iter == CW'(NI - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_iter = r_iter + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_iter <= n_iter;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_done  = r_done;
    assign o_res.x = r_x;
    assign o_res.z = r_z;

endmodule

>>> rtl/gtp_post.sv
`timescale 1ns / 1ps
// Post-processing steps: gain correction to distance, bearing error, speed limit and wheel mix.
// Depends on gtp_pkg for widths, scaling constants and the result structs.
module gtp_post import gtp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_cordic_res       i_res,
    input  logic [HEAD_W-1:0] i_heading,
    output logic              o_done,
    output t_post_res         o_res
);

    localparam int PROD_W = CX_W - 1 + INV_GAIN_W;
    localparam int DIST_W = PROD_W + 1 - DIST_SHIFT;
    localparam int ERR_W  = CZ_W - 16 + 2;
    localparam int TURN_W = ERR_W - 3;
    localparam int MIX_W  = TURN_W + 1;
    localparam int Q_W    = DIV_IN_W + DIV20_W;

    logic [CX_W-2:0]          w_xc;
    logic signed [CZ_W:0]     w_zr;
    logic signed [ERR_W-1:0]  w_err;
    logic [PROD_W:0]          w_sum;
    logic [FWD_W-1:0]         w_fwd;
    logic signed [TURN_W-1:0] w_turn;
    logic signed [MIX_W-1:0]  w_left, w_right;

    logic [PROD_W-1:0]        r_prod;
    logic signed [ERR_W-1:0]  r_err;
    logic [DIST_W-1:0]        r_dist;
    logic [Q_W-1:0]           r_q;
    logic                     r_cap, r_near;
    logic                     r_v1, r_v2, r_v3, r_v4;
    t_post_res                r_res;

    assign w_xc  = (i_res.x < 0) ? '0 : i_res.x[CX_W-2:0];
    assign w_zr  = {i_res.z[CZ_W-1], i_res.z} + (CZ_W+1)'(32768);
    assign w_err = {w_zr[CZ_W], w_zr[CZ_W:16]} - {3'b000, i_heading};
    assign w_sum = {1'b0, r_prod} + ((PROD_W+1)'(1) << (DIST_SHIFT - 1));

    assign w_fwd   = r_cap ? FWD_W'(FWD_CAP) : r_q[DIV20_SHIFT +: FWD_W];
    assign w_turn  = r_err[ERR_W-1:3];
    assign w_left  = MIX_W'(w_fwd) + MIX_W'(w_turn);
    assign w_right = MIX_W'(w_fwd) - MIX_W'(w_turn);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= PROD_W'(w_xc) * PROD_W'(INV_GAIN_Q30);
            r_err  <= w_err;
        end
        if (r_v1) begin
            r_dist <= w_sum[PROD_W:DIST_SHIFT];
        end
        if (r_v2) begin
            r_q    <= Q_W'(r_dist[DIV_IN_W-1:0]) * Q_W'(DIV20_RECIP);
            r_cap  <= (r_dist >= DIST_W'(FWD_CAP_DIST));
            r_near <= (r_dist < DIST_W'(ARRIVE_DIST));
        end
        if (r_v3) begin
            r_res.near  <= r_near;
            r_res.left  <= w_left[SPD_W-1:0];
            r_res.right <= w_right[SPD_W-1:0];
        end
    end

    assign o_done = r_v4;
    assign o_res  = r_res;

endmodule
